>>> hdl/kngm_pkg.sv
// Shared types, constants and state encodings for the gap min-sum block.
`default_nettype none
package kngm_pkg;

  // Value of a retired or boundary gap
  localparam logic [63:0] SENTINEL = 64'd9876543219876543;
  localparam int unsigned KW = 10;

  typedef struct packed {
    logic [31:0] time_value;
    logic        is_last;
  } item_t;

  typedef struct packed {
    logic [62:0] total_gap;
    logic        infeasible;
  } result_t;

  // One gap per beat, nodes in order 1 .. n+1
  typedef struct packed {
    logic        valid;
    logic        last;
    logic [63:0] value;
  } gap_beat_t;

  typedef enum logic [1:0] {
    T_LOAD,
    T_RUN,
    T_OUT
  } top_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDV,
    S_WV,
    S_CMP,
    S_PUT,
    S_GHEAD,
    S_GFIRST,
    S_GBODY,
    S_GTAIL
  } sort_state_t;

  typedef enum logic [3:0] {
    G_IDLE,
    G_FILL,
    G_SCAN,
    G_SCANEND,
    G_RDLINK,
    G_GETLINK,
    G_GETLV,
    G_GETRV,
    G_MERGE,
    G_UNL,
    G_RDR,
    G_UNR,
    G_NEXT,
    G_DONE
  } greedy_state_t;

endpackage
`default_nettype wire

>>> hdl/kngm_sort.sv
// Point memory: loading, in-place insertion sort and gap streaming.
`default_nettype none
module kngm_sort import kngm_pkg::*; #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               ld_we,
  input  wire logic [$clog2(MAX_POINTS)-1:0]      ld_addr,
  input  wire logic [31:0]                        ld_data,
  input  wire logic                               go,
  input  wire logic [$clog2(MAX_POINTS+1)-1:0]    n,
  output gap_beat_t                               beat
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned NW = $clog2(MAX_POINTS + 2);

  logic [31:0] mem [MAX_POINTS];
  logic [31:0] rdata;

  sort_state_t state, state_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [NW-1:0] gi;
  logic [31:0]   v;
  logic [31:0]   prev;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;

  // Memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (go) begin
          state_next = (n == CW'(1)) ? S_GHEAD : S_RDV;
        end
      end
      S_RDV:  state_next = S_WV;
      S_WV:   state_next = S_CMP;
      S_CMP: begin
        if (rdata <= v || j == CW'(1)) begin
          state_next = S_PUT;
        end
      end
      S_PUT:    state_next = (i + CW'(1) == cnt) ? S_GHEAD : S_RDV;
      S_GHEAD:  state_next = S_GFIRST;
      S_GFIRST: state_next = (cnt == CW'(1)) ? S_GTAIL : S_GBODY;
      S_GBODY:  state_next = (NW'(cnt) == gi) ? S_GTAIL : S_GBODY;
      S_GTAIL:  state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Memory controls and gap beats
  always_comb begin
    we         = 1'b0;
    waddr      = ld_addr;
    wdata      = ld_data;
    raddr      = '0;
    beat.valid = 1'b0;
    beat.last  = 1'b0;
    beat.value = SENTINEL;
    case (state)
      S_IDLE: begin
        we = ld_we;
      end
      S_RDV: raddr = i[AW-1:0];
      S_WV:  raddr = AW'(i - CW'(1));
      S_CMP: begin
        if (rdata > v) begin
          we    = 1'b1;
          waddr = j[AW-1:0];
          wdata = rdata;
          raddr = AW'(j - CW'(2));
        end
      end
      S_PUT: begin
        we    = 1'b1;
        waddr = j[AW-1:0];
        wdata = v;
      end
      S_GHEAD: begin
        beat.valid = 1'b1;
        raddr      = '0;
      end
      S_GFIRST: raddr = AW'(1);
      S_GBODY: begin
        beat.valid = 1'b1;
        beat.value = {32'd0, rdata - prev};
        raddr      = gi[AW-1:0];
      end
      S_GTAIL: begin
        beat.valid = 1'b1;
        beat.last  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sort and stream registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    case (state)
      S_IDLE: begin
        cnt <= n;
        i   <= CW'(1);
      end
      S_WV: begin
        v <= rdata;
        j <= i;
      end
      S_CMP: begin
        if (rdata > v) begin
          j <= j - CW'(1);
        end
      end
      S_PUT: i <= i + CW'(1);
      S_GFIRST: begin
        prev <= rdata;
        gi   <= NW'(2);
      end
      S_GBODY: begin
        prev <= rdata;
        gi   <= gi + NW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/kngm_greedy.sv
// Gap, link and leaf memories with the regret-greedy pick sequencer.
`default_nettype none
module kngm_greedy import kngm_pkg::*; #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            go,
  input  wire logic [KW-1:0]   k,
  input  wire gap_beat_t       beat,
  output logic                 done,
  output logic [63:0]          total
);

  localparam int unsigned NODES = MAX_POINTS + 2;
  localparam int unsigned NW    = $clog2(NODES);

  logic [63:0]   gap_mem [NODES];
  logic [63:0]   val_mem [NODES];
  logic [NW-1:0] lft_mem [NODES];
  logic [NW-1:0] rgt_mem [NODES];

  logic [63:0]   gdat, vdat;
  logic [NW-1:0] ldat, rdat;

  // Port controls
  logic          g_we, v_we, l_we, r_we;
  logic [NW-1:0] g_wa, v_wa, l_wa, r_wa;
  logic [63:0]   g_wd, v_wd;
  logic [NW-1:0] l_wd, r_wd;
  logic [NW-1:0] g_ra, v_ra, k_ra;

  greedy_state_t state, state_next;
  logic [KW-1:0] kreg, round;
  logic [NW-1:0] fc, n1, sa, sidx, best, l, r;
  logic          sv;
  logic [63:0]   bval, lv, sum;
  logic [63:0]   newv;

  assign newv = sum - bval;

  // Memories
  always_ff @(posedge clk) begin
    if (g_we) gap_mem[g_wa] <= g_wd;
    if (v_we) val_mem[v_wa] <= v_wd;
    if (l_we) lft_mem[l_wa] <= l_wd;
    if (r_we) rgt_mem[r_wa] <= r_wd;
    gdat <= gap_mem[g_ra];
    vdat <= val_mem[v_ra];
    ldat <= lft_mem[k_ra];
    rdat <= rgt_mem[k_ra];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      G_IDLE:    if (go) state_next = G_FILL;
      G_FILL:    if (beat.valid && beat.last) state_next = G_SCAN;
      G_SCAN:    if (sa == n1) state_next = G_SCANEND;
      G_SCANEND: state_next = G_RDLINK;
      G_RDLINK:  state_next = G_GETLINK;
      G_GETLINK: state_next = G_GETLV;
      G_GETLV:   state_next = G_GETRV;
      G_GETRV:   state_next = G_MERGE;
      G_MERGE:   state_next = (l != '0) ? G_UNL : G_RDR;
      G_UNL:     state_next = G_RDR;
      G_RDR:     state_next = (r != '0) ? G_UNR : G_NEXT;
      G_UNR:     state_next = G_NEXT;
      G_NEXT:    state_next = (round + KW'(1) == kreg) ? G_DONE : G_SCAN;
      G_DONE:    state_next = G_IDLE;
      default:   state_next = G_IDLE;
    endcase
  end

  // Memory controls
  always_comb begin
    g_we = 1'b0; v_we = 1'b0; l_we = 1'b0; r_we = 1'b0;
    g_wa = fc;   v_wa = fc;   l_wa = fc;   r_wa = fc;
    g_wd = beat.value;
    v_wd = beat.value;
    l_wd = fc - NW'(1);
    r_wd = beat.last ? '0 : fc + NW'(1);
    g_ra = l;
    v_ra = sa;
    k_ra = best;
    done = 1'b0;
    case (state)
      G_FILL: begin
        g_we = beat.valid;
        v_we = beat.valid;
        l_we = beat.valid;
        r_we = beat.valid;
      end
      G_GETLINK: g_ra = ldat;
      G_GETLV:   g_ra = r;
      G_MERGE: begin
        g_we = 1'b1;
        g_wa = best;
        g_wd = newv;
        v_we = 1'b1;
        v_wa = best;
        v_wd = newv;
        k_ra = l;
      end
      G_UNL, G_UNR: begin
        // Retire the neighbor and splice it out of the list
        v_we = 1'b1;
        v_wa = (state == G_UNL) ? l : r;
        v_wd = SENTINEL;
        l_we = (rdat != '0);
        l_wa = rdat;
        l_wd = ldat;
        r_we = (ldat != '0);
        r_wa = ldat;
        r_wd = rdat;
      end
      G_RDR:  k_ra = r;
      G_DONE: done = 1'b1;
      default: begin
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
    end else begin
      state <= state_next;
    end
    sv   <= (state == G_SCAN);
    sidx <= sa;
    // Running minimum, lowest index wins ties
    if (sv && (sidx == NW'(1) || vdat < bval)) begin
      best <= sidx;
      bval <= vdat;
    end
    case (state)
      G_IDLE: begin
        fc    <= NW'(1);
        kreg  <= k;
        round <= '0;
        total <= '0;
        sa    <= NW'(1);
      end
      G_FILL: begin
        if (beat.valid) begin
          fc <= fc + NW'(1);
          n1 <= fc;
        end
      end
      G_SCAN:    sa <= sa + NW'(1);
      G_GETLINK: begin
        l <= ldat;
        r <= rdat;
      end
      G_GETLV: lv  <= (l != '0) ? gdat : SENTINEL;
      G_GETRV: sum <= lv + ((r != '0) ? gdat : SENTINEL);
      G_MERGE: total <= total + bval;
      G_NEXT: begin
        round <= round + KW'(1);
        sa    <= NW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/k_nonadjacent_gap_min_sum_core.sv
// Top level: point loading, set control, result register and checks.
//
// Usage: points arrive on item, one per cycle while busy is low, taken
// at an edge with start high. The point with is_last set closes the set.
// pick_count is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, the block itself does not enforce this.
// After the last point busy rises and one result appears on result with
// done high for exactly one cycle; then busy falls and a new set may load.
// Work after the last point:
//   - pick_count zero or 2*pick_count above the point count: done is high
//     in the cycle right after the closing edge;
//   - otherwise the block runs an insertion sort on the point memory,
//     streams the gaps, makes per pick a full scan of the leaf memory
//     plus the link update sequence, and then hands over the result.
// Loading runs at one point per cycle while busy is low; the sort loop
// and the per-pick scan of the leaf memory set the time to the result.
// Reset returns pick_count to 1 and empties the point set; no memory is
// cleared, each set rebuilds what it reads. Results cannot be stalled.
`default_nettype none
module k_nonadjacent_gap_min_sum_core import kngm_pkg::*; #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire item_t           item,
  output logic                 done,
  output result_t              result,
  input  wire logic            cfg_we,
  input  wire logic [KW-1:0]   cfg_wdata
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  top_state_t    state, state_next;
  logic [KW-1:0] pick_count;
  logic [CW-1:0] point_count, n_new;
  logic          accept, room, fin, skip, infeas;
  logic          s_go;
  gap_beat_t     beat;
  logic          g_done;
  logic [63:0]   g_total;

  assign accept = start && !busy;
  assign room   = (point_count < CW'(MAX_POINTS));
  assign n_new  = room ? point_count + CW'(1) : point_count;
  assign fin    = accept && item.is_last;
  assign infeas = ({pick_count, 1'b0} > (KW + 1)'(n_new)) && (CW <= KW + 1)
                  || ((CW > KW + 1) && (CW'({pick_count, 1'b0}) > n_new));
  assign skip   = (pick_count == '0) || infeas;

  kngm_sort #(.MAX_POINTS(MAX_POINTS)) u_sort (
    .clk     (clk),
    .rst     (rst),
    .ld_we   (accept && room),
    .ld_addr (point_count[AW-1:0]),
    .ld_data (item.time_value),
    .go      (s_go),
    .n       (n_new),
    .beat    (beat)
  );

  kngm_greedy #(.MAX_POINTS(MAX_POINTS)) u_greedy (
    .clk   (clk),
    .rst   (rst),
    .go    (s_go),
    .k     (pick_count),
    .beat  (beat),
    .done  (g_done),
    .total (g_total)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      T_LOAD:  if (fin) state_next = skip ? T_OUT : T_RUN;
      T_RUN:   if (g_done) state_next = T_OUT;
      T_OUT:   state_next = T_LOAD;
      default: state_next = T_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    busy = 1'b1;
    done = 1'b0;
    s_go = 1'b0;
    case (state)
      T_LOAD: begin
        busy = 1'b0;
        s_go = fin && !skip;
      end
      T_OUT:   done = 1'b1;
      default: begin
      end
    endcase
  end

  // Control and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= T_LOAD;
      pick_count  <= KW'(1);
      point_count <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        pick_count <= cfg_wdata;
      end
      if (fin) begin
        point_count <= '0;
      end else if (accept) begin
        point_count <= n_new;
      end
    end
    if (fin && skip) begin
      result.total_gap  <= '0;
      result.infeasible <= infeas;
    end else if (state == T_RUN && g_done) begin
      result.total_gap  <= g_total[62:0];
      result.infeasible <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.is_last) |=> busy)
    else $error("block idle after closing point");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_gdone_run: assert property (@(posedge clk) disable iff (rst)
    g_done |-> (state == T_RUN))
    else $error("greedy finished outside a run");
`endif

endmodule
`default_nettype wire

>>> verif/k_nonadjacent_gap_min_sum_core_tb.sv
// Self-checking testbench for the non-adjacent gap min-sum core.
`timescale 1ns / 1ps
module k_nonadjacent_gap_min_sum_core_tb;
  import kngm_pkg::*;

  localparam int unsigned POINT_CAP = 128;
  localparam longint unsigned CYCLE_LIMIT = 1000000;

  // Value patterns for a generated point set
  typedef enum int {
    PAT_WIDE,
    PAT_TIES,
    PAT_RISING,
    PAT_FALLING
  } pattern_t;

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  item_t           item;
  logic            done;
  result_t         result;
  logic            cfg_we;
  logic [KW-1:0]   cfg_wdata;

  // Predictor state
  logic [31:0]     set_points[$];
  int unsigned     pick_setting;
  result_t         pending_totals[$];

  int unsigned     err_count;
  int unsigned     sets_checked;
  int unsigned     infeasible_seen;
  int unsigned     points_sent;
  longint unsigned cycle_count;
  bit              calm;

  k_nonadjacent_gap_min_sum_core #(.MAX_POINTS(POINT_CAP)) uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Regret greedy over the sorted gaps of one set
  function automatic result_t min_gap_total(input logic [31:0] pts[$], input int unsigned k);
    logic [63:0] gap[0:POINT_CAP+1];
    logic [63:0] leaf[0:POINT_CAP+1];
    int unsigned lft[0:POINT_CAP+1];
    int unsigned rgt[0:POINT_CAP+1];
    int unsigned n;
    int unsigned best;
    int unsigned l;
    int unsigned r;
    logic [63:0] tot;
    logic [63:0] p;
    logic [63:0] lv;
    logic [63:0] rv;
    result_t res;
    n = pts.size();
    res = '0;
    if (2 * k > n) begin
      res.infeasible = 1'b1;
      return res;
    end
    pts.sort();
    for (int i = 0; i <= POINT_CAP + 1; i++) begin
      leaf[i] = SENTINEL;
    end
    gap[1] = SENTINEL;
    gap[n+1] = SENTINEL;
    for (int unsigned i = 2; i <= n; i++) begin
      gap[i] = {32'd0, pts[i-1]} - {32'd0, pts[i-2]};
    end
    for (int unsigned i = 1; i <= n + 1; i++) begin
      lft[i] = i - 1;
      rgt[i] = (i == n + 1) ? 0 : i + 1;
      leaf[i] = gap[i];
    end
    tot = '0;
    for (int unsigned rd = 0; rd < k; rd++) begin
      best = 1;
      for (int unsigned i = 2; i <= n + 1; i++) begin
        if (leaf[i] < leaf[best]) best = i;
      end
      p = leaf[best];
      tot = tot + p;
      l = lft[best];
      r = rgt[best];
      lv = (l != 0) ? gap[l] : SENTINEL;
      rv = (r != 0) ? gap[r] : SENTINEL;
      gap[best] = lv + rv - p;
      // retire both neighbours and splice them out of the list
      if (l != 0) begin
        leaf[l] = SENTINEL;
        if (rgt[l] != 0) lft[rgt[l]] = lft[l];
        if (lft[l] != 0) rgt[lft[l]] = rgt[l];
      end
      if (r != 0) begin
        leaf[r] = SENTINEL;
        if (rgt[r] != 0) lft[rgt[r]] = lft[r];
        if (lft[r] != 0) rgt[lft[r]] = rgt[r];
      end
      leaf[best] = gap[best];
    end
    res.total_gap = tot[62:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_count++;
    $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // Result checker: the receiver never stalls, so every done pulse counts
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_totals.size() == 0) begin
        report_mismatch("unexpected result", {result.total_gap, result.infeasible},
                        64'd0);
      end else begin
        result_t want;
        want = pending_totals.pop_front();
        if (result.total_gap !== want.total_gap)
          report_mismatch("total_gap", {1'b0, result.total_gap},
                          {1'b0, want.total_gap});
        if (result.infeasible !== want.infeasible)
          report_mismatch("infeasible", {63'd0, result.infeasible},
                          {63'd0, want.infeasible});
        sets_checked++;
        if (want.infeasible) infeasible_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // One point transaction; start stays high until an idle gap lowers it
  task automatic send_point(input logic [31:0] value, input logic last);
    while (!calm && $urandom_range(99) < 36) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item.time_value <= value;
    item.is_last <= last;
    do @(posedge clk); while (busy);
    points_sent++;
    if (set_points.size() < POINT_CAP) set_points = {set_points, value};
    if (last) begin
      pending_totals = {pending_totals, min_gap_total(set_points, pick_setting)};
      set_points.delete();
    end
  endtask

  task automatic send_set(input int unsigned n, input pattern_t pat);
    logic [31:0] base;
    logic [31:0] v;
    base = $urandom;
    for (int unsigned i = 0; i < n; i++) begin
      case (pat)
        PAT_WIDE: begin
          v = $urandom;
        end
        PAT_TIES: begin
          v = base + $urandom_range(7);
        end
        PAT_RISING: begin
          v = i * 3 + $urandom_range(2);
        end
        default: begin
          v = 32'hFFFF_FFFF - i * 5;
        end
      endcase
      send_point(v, i == n - 1);
    end
  endtask

  // Let all results arrive and the block settle before a register write
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_totals.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_picks(input int unsigned k);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= k[KW-1:0];
    @(posedge clk);
    pick_setting = k;
    cfg_we <= 1'b0;
  endtask

  // Small hand-built sets: boundaries, ties, extreme values
  task automatic test_directed;
    set_picks(1);
    send_point(32'd5, 1'b1);
    send_point(32'd0, 1'b0);
    send_point(32'hFFFF_FFFF, 1'b1);
    send_point(32'd9, 1'b0);
    send_point(32'd9, 1'b0);
    send_point(32'd9, 1'b1);
    set_picks(2);
    send_point(32'd1, 1'b0);
    send_point(32'd4, 1'b0);
    send_point(32'd2, 1'b0);
    send_point(32'd100, 1'b0);
    send_point(32'd101, 1'b1);
    send_point(32'hFFFF_FFFF, 1'b0);
    send_point(32'h0000_0000, 1'b0);
    send_point(32'h8000_0000, 1'b1);
    set_picks(0);
    send_point(32'd7, 1'b0);
    send_point(32'd3, 1'b1);
  endtask

  // Register extremes, including the unused top codes
  task automatic test_pick_extremes;
    set_picks(1023);
    send_set(6, PAT_WIDE);
    set_picks(512);
    send_set(20, PAT_TIES);
    set_picks(POINT_CAP / 2);
    send_set(POINT_CAP, PAT_RISING);
    set_picks(POINT_CAP / 3);
    send_set(2 * (POINT_CAP / 3), PAT_FALLING);
  endtask

  // More than the store holds: extra points are dropped, the closing mark still closes the set
  task automatic test_overflow;
    set_picks(3);
    for (int unsigned i = 0; i < POINT_CAP + 5; i++) begin
      send_point(32'h1000 + i * 7, 1'b0);
    end
    send_point(32'h0, 1'b1);
    send_set(4, PAT_WIDE);
  endtask

  task automatic test_random;
    int unsigned sent;
    int unsigned sz;
    pattern_t pat;
    sent = 0;
    while (sent < 220) begin
      if ($urandom_range(9) == 0) set_picks($urandom_range(1, 6));
      calm = (sent > 60 && sent < 160);
      sz = ($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 14);
      case ($urandom_range(3))
        0: pat = PAT_TIES;
        1: pat = PAT_RISING;
        2: pat = PAT_FALLING;
        default: pat = PAT_WIDE;
      endcase
      send_set(sz, pat);
      sent += sz;
    end
    calm = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    pick_setting = 1;
    err_count = 0;
    sets_checked = 0;
    infeasible_seen = 0;
    points_sent = 0;
    cycle_count = 0;
    calm = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_pick_extremes();
    test_overflow();
    test_random();

    drain();
    repeat (40) @(posedge clk);
    $display("Covered %0d points in %0d sets (%0d infeasible), picks 0 to 1023,",
             points_sent, sets_checked, infeasible_seen);
    $display("full and overflowing point stores, ties and extreme values.");
    if (err_count == 0 && pending_totals.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Leftover expectations: %0d, mismatches: %0d",
               pending_totals.size(), err_count);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
